// ----- hw/rtl/cfr_pkg.sv -----
// ============================================================================
// cfr_pkg: shared types and constants of the checked frame receiver
// Holds the result record, configuration indexes, frame ids and action codes.
// ============================================================================
`default_nettype none

package cfr_pkg;

    // Default sizing
    localparam int MAX_PAYLOAD_DEF = 128;
    localparam int CMD_SLOTS_DEF   = 32;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 9;
    localparam int ACT_W    = 3;
    localparam int PID_W    = 16;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 1'd1;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] SYNC_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] ADDR_RST = 8'hFF;
    localparam logic [BYTE_W-1:0] ADDR_BCAST = 8'h00;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Frame ids
    localparam logic [BYTE_W-1:0] ID_CAL   = 8'hE0;
    localparam logic [BYTE_W-1:0] ID_READ  = 8'hE1;
    localparam logic [BYTE_W-1:0] ID_WRITE = 8'hE2;

    // Calibration sub-codes
    localparam logic [BYTE_W-1:0] CAL_GROUP      = 8'h01;
    localparam logic [BYTE_W-1:0] CAL_GYRO       = 8'h02;
    localparam logic [BYTE_W-1:0] CAL_MAG        = 8'h04;
    localparam logic [BYTE_W-1:0] CAL_ACC        = 8'h05;
    localparam logic [BYTE_W-1:0] CAL_CANCEL_MAG = 8'h10;

    // Dispatch actions
    localparam logic [ACT_W-1:0] ACT_NONE       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_GYRO_CAL   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_MAG_CAL    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ACC_CAL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CANCEL_MAG = 3'd4;
    localparam logic [ACT_W-1:0] ACT_PARAM_RD   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_PARAM_WR   = 3'd6;

    // Parser positions of the header bytes
    localparam logic [POS_W-1:0] POS_HUNT = 9'd0;
    localparam logic [POS_W-1:0] POS_ADDR = 9'd1;
    localparam logic [POS_W-1:0] POS_ID   = 9'd2;
    localparam logic [POS_W-1:0] POS_LEN  = 9'd3;
    localparam logic [POS_W-1:0] POS_PAY  = 9'd4;

    // One result beat
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] frame_id;
        logic [BYTE_W-1:0] frame_len;
        logic              check_ok;
        logic [BYTE_W-1:0] sum_value;
        logic [BYTE_W-1:0] add_value;
        logic [ACT_W-1:0]  action;
        logic              reply_needed;
        logic [PID_W-1:0]  param_id;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/cfr_parser.sv -----
// ============================================================================
// cfr_parser: frame parser and check accumulator
// Walks one received byte per beat through the frame layout, keeps the
// running sum and add checks, and forms the payload or frame-end result.
// ============================================================================
`default_nettype none

module cfr_parser
    import cfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int CMD_SLOTS   = CMD_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_beat,
    input  wire logic [BYTE_W-1:0] i_rx_byte,
    input  wire logic [BYTE_W-1:0] i_sync_byte,
    input  wire logic [BYTE_W-1:0] i_dev_addr,
    output logic                   o_res_valid,
    output t_result                o_res
);

    logic [POS_W-1:0]  r_pos,  n_pos;
    logic [BYTE_W-1:0] r_id,   n_id;
    logic [BYTE_W-1:0] r_len,  n_len;
    logic [BYTE_W-1:0] r_sum,  n_sum;
    logic [BYTE_W-1:0] r_add,  n_add;
    logic [BYTE_W-1:0] r_pay0, n_pay0;
    logic [BYTE_W-1:0] r_pay1, n_pay1;
    logic [BYTE_W-1:0] r_pay2, n_pay2;
    logic [BYTE_W-1:0] r_rsum, n_rsum;

    logic [BYTE_W-1:0] sum_acc;
    logic [BYTE_W-1:0] add_acc;
    logic [POS_W-1:0]  pay_end;
    logic [POS_W-1:0]  idx;
    logic [PID_W-1:0]  pid;
    logic              pid_in_range;
    logic              ok;
    logic [ACT_W-1:0]  cal_act;
    logic [ACT_W-1:0]  act;
    logic              reply;

    // Checksum step for the current byte
    assign sum_acc = r_sum + i_rx_byte;
    assign add_acc = r_add + sum_acc;

    // Frame layout helpers
    assign pay_end      = {1'b0, r_len} + POS_PAY;
    assign idx          = r_pos - POS_PAY;
    assign pid          = {r_pay1, r_pay0};
    assign pid_in_range = {1'b0, pid} < (PID_W+1)'(CMD_SLOTS);
    assign ok           = (r_rsum == r_sum) && (i_rx_byte == r_add);

    // Calibration sub-command decode
    always_comb begin
        cal_act = ACT_NONE;
        if (r_pay0 == CAL_GROUP) begin
            unique case (r_pay2)
                CAL_GYRO:       cal_act = ACT_GYRO_CAL;
                CAL_MAG:        cal_act = ACT_MAG_CAL;
                CAL_ACC:        cal_act = ACT_ACC_CAL;
                CAL_CANCEL_MAG: cal_act = ACT_CANCEL_MAG;
                default:        cal_act = ACT_NONE;
            endcase
        end
    end

    // Dispatch, only on a good frame
    always_comb begin
        act   = ACT_NONE;
        reply = 1'b0;
        if (ok) begin
            unique case (r_id)
                ID_CAL: begin
                    reply = 1'b1;
                    act   = cal_act;
                end
                ID_READ: begin
                    if (pid_in_range) act = ACT_PARAM_RD;
                end
                ID_WRITE: begin
                    reply = 1'b1;
                    if (pid_in_range) act = ACT_PARAM_WR;
                end
                default: begin
                    act   = ACT_NONE;
                    reply = 1'b0;
                end
            endcase
        end
    end

    // Next state and result for one beat
    always_comb begin
        n_pos  = r_pos;
        n_id   = r_id;
        n_len  = r_len;
        n_sum  = r_sum;
        n_add  = r_add;
        n_pay0 = r_pay0;
        n_pay1 = r_pay1;
        n_pay2 = r_pay2;
        n_rsum = r_rsum;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.frame_id  = r_id;
        o_res.frame_len = r_len;
        if (i_beat) begin
            priority if (r_pos == POS_HUNT) begin
                if (i_rx_byte == i_sync_byte) begin
                    n_pay0 = '0;
                    n_pay1 = '0;
                    n_pay2 = '0;
                    n_sum  = i_rx_byte;
                    n_add  = i_rx_byte;
                    n_pos  = POS_ADDR;
                end
            end else if (r_pos == POS_ADDR) begin
                if (i_rx_byte == i_dev_addr || i_rx_byte == ADDR_BCAST) begin
                    n_sum = sum_acc;
                    n_add = add_acc;
                    n_pos = POS_ID;
                end else begin
                    n_pos = POS_HUNT;
                end
            end else if (r_pos == POS_ID) begin
                n_id  = i_rx_byte;
                n_sum = sum_acc;
                n_add = add_acc;
                n_pos = POS_LEN;
            end else if (r_pos == POS_LEN) begin
                if (i_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                    n_pos = POS_HUNT;
                end else begin
                    n_len = i_rx_byte;
                    n_sum = sum_acc;
                    n_add = add_acc;
                    n_pos = POS_PAY;
                end
            end else if (r_pos < pay_end) begin
                // tentative payload byte
                if (idx == 9'd0) n_pay0 = i_rx_byte;
                if (idx == 9'd1) n_pay1 = i_rx_byte;
                if (idx == 9'd2) n_pay2 = i_rx_byte;
                n_sum = sum_acc;
                n_add = add_acc;
                n_pos = r_pos + 9'd1;
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_PAYLOAD;
                o_res.byte_index   = idx[BYTE_W-1:0];
                o_res.payload_byte = i_rx_byte;
            end else if (r_pos == pay_end) begin
                n_rsum = i_rx_byte;
                n_pos  = r_pos + 9'd1;
            end else if (r_pos == pay_end + 9'd1) begin
                // frame end report
                n_pos = POS_HUNT;
                o_res_valid        = 1'b1;
                o_res.kind         = KIND_END;
                o_res.check_ok     = ok;
                o_res.sum_value    = r_sum;
                o_res.add_value    = r_add;
                o_res.action       = act;
                o_res.reply_needed = reply;
                o_res.param_id     = pid;
            end else begin
                n_pos = POS_HUNT;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUNT;
            r_id   <= '0;
            r_len  <= '0;
            r_sum  <= '0;
            r_add  <= '0;
            r_pay0 <= '0;
            r_pay1 <= '0;
            r_pay2 <= '0;
            r_rsum <= '0;
        end else begin
            r_pos  <= n_pos;
            r_id   <= n_id;
            r_len  <= n_len;
            r_sum  <= n_sum;
            r_add  <= n_add;
            r_pay0 <= n_pay0;
            r_pay1 <= n_pay1;
            r_pay2 <= n_pay2;
            r_rsum <= n_rsum;
        end
    end

    // Position stays within the frame that the held length describes
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= pay_end + 9'd1)
        else $error("parser position beyond frame end");

    // Held length never exceeds the payload limit
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= BYTE_W'(MAX_PAYLOAD))
        else $error("held length above payload limit");

    // No result while hunting for sync
    a_hunt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == POS_HUNT) |-> !o_res_valid)
        else $error("result produced while hunting");

    // A frame end report returns the parser to hunting
    a_end_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_END) |=> (r_pos == POS_HUNT))
        else $error("parser not hunting after frame end");

endmodule

`default_nettype wire

// ----- hw/rtl/cfr_out_reg.sv -----
// ============================================================================
// cfr_out_reg: result output register
// Holds one result beat for the consumer and accepts a new one in the
// same cycle that the held beat is taken.
// ============================================================================
`default_nettype none

module cfr_out_reg
    import cfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held beat leaves this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/checked_frame_receiver_core.sv -----
// ============================================================================
// checked_frame_receiver_core: byte-serial frame receiver with sum/add checks
// Hunts the received byte stream for frames, reports payload bytes as they
// arrive and closes each frame with a check verdict and dispatch action.
// ============================================================================
// Each result is registered and appears on the output in the cycle after its byte beat.
// One byte per cycle unless the consumer stalls; the parser state and both
// checks update as the beat is taken, and the output register frees as taken.
// Reset (synchronous, active low): parser hunts for sync, checks and held
// fields clear, sync byte returns to 0xAA and device address to 0xFF.
`default_nettype none

module checked_frame_receiver_core
    import cfr_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int CMD_SLOTS   = CMD_SLOTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [BYTE_W-1:0]    i_cfg_data,
    // received bytes
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [BYTE_W-1:0]    i_rx_byte,
    // results
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic                      o_kind,
    output logic [BYTE_W-1:0]         o_byte_index,
    output logic [BYTE_W-1:0]         o_payload_byte,
    output logic [BYTE_W-1:0]         o_frame_id,
    output logic [BYTE_W-1:0]         o_frame_len,
    output logic                      o_check_ok,
    output logic [BYTE_W-1:0]         o_sum_value,
    output logic [BYTE_W-1:0]         o_add_value,
    output logic [ACT_W-1:0]          o_action,
    output logic                      o_reply_needed,
    output logic [PID_W-1:0]          o_param_id
);

    logic [BYTE_W-1:0] r_sync_byte;
    logic [BYTE_W-1:0] r_dev_addr;
    logic              beat;
    logic              res_valid;
    t_result           res;
    t_result           out_res;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_RST;
            r_dev_addr  <= ADDR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_BYTE: r_sync_byte <= i_cfg_data;
                CFG_DEV_ADDR:  r_dev_addr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input beat accepted
    assign beat = i_in_valid && o_in_ready;

    cfr_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .CMD_SLOTS   (CMD_SLOTS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_rx_byte   (i_rx_byte),
        .i_sync_byte (r_sync_byte),
        .i_dev_addr  (r_dev_addr),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cfr_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_res   (res),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (out_res)
    );

    // Result fields
    assign o_kind         = out_res.kind;
    assign o_byte_index   = out_res.byte_index;
    assign o_payload_byte = out_res.payload_byte;
    assign o_frame_id     = out_res.frame_id;
    assign o_frame_len    = out_res.frame_len;
    assign o_check_ok     = out_res.check_ok;
    assign o_sum_value    = out_res.sum_value;
    assign o_add_value    = out_res.add_value;
    assign o_action       = out_res.action;
    assign o_reply_needed = out_res.reply_needed;
    assign o_param_id     = out_res.param_id;

endmodule

`default_nettype wire

// ----- test/tb_checked_frame_receiver_core.sv -----
// ============================================================================
// tb_checked_frame_receiver_core: self-checking bench of the frame receiver
// Feeds byte streams of well-formed, corrupted and broken frames under several
// sync/address settings, predicts every payload and frame-end beat in step with
// the accepted input, and compares the results field by field under random
// input gaps and output backpressure.
// ============================================================================
`default_nettype none

module tb_checked_frame_receiver_core;
    import cfr_pkg::*;

    localparam int ITEMS          = 1500;
    localparam int PHASES         = 6;
    localparam int CFG_DRAIN      = 4;     // quiet cycles before a register write
    localparam int LONG_HOLD      = 300;   // one long receiver hold-off
    localparam int CALM_TAIL      = 200;   // last bytes run with no idling
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [BYTE_W-1:0] CAL_UNKNOWN = 8'h03;
    localparam logic [BYTE_W-1:0] CAL_CODES [5] =
        '{CAL_GYRO, CAL_MAG, CAL_ACC, CAL_CANCEL_MAG, CAL_UNKNOWN};

    // one beat waiting for the driver: a received byte or a register write
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [BYTE_W-1:0]    data;
    } t_feed_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_SYNC_BYTE;
    logic [BYTE_W-1:0]     i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic [BYTE_W-1:0]     i_rx_byte = '0;
    logic                  i_out_ready = 1'b0;
    logic                  o_cfg_ready;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_kind;
    logic [BYTE_W-1:0]     o_byte_index;
    logic [BYTE_W-1:0]     o_payload_byte;
    logic [BYTE_W-1:0]     o_frame_id;
    logic [BYTE_W-1:0]     o_frame_len;
    logic                  o_check_ok;
    logic [BYTE_W-1:0]     o_sum_value;
    logic [BYTE_W-1:0]     o_add_value;
    logic [ACT_W-1:0]      o_action;
    logic                  o_reply_needed;
    logic [PID_W-1:0]      o_param_id;

    checked_frame_receiver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_frame_id     (o_frame_id),
        .o_frame_len    (o_frame_len),
        .o_check_ok     (o_check_ok),
        .o_sum_value    (o_sum_value),
        .o_add_value    (o_add_value),
        .o_action       (o_action),
        .o_reply_needed (o_reply_needed),
        .o_param_id     (o_param_id)
    );

    // stimulus side
    t_feed_beat         feed_q[$];
    int                 n_bytes_total = 0;
    logic [BYTE_W-1:0]  gen_sync = SYNC_RST;
    logic [BYTE_W-1:0]  gen_addr = ADDR_RST;
    logic [BYTE_W-1:0]  gen_sum;
    logic [BYTE_W-1:0]  gen_add;
    logic [BYTE_W-1:0]  pl_buf [0:255];

    // prediction side
    t_result            expected_results[$];
    logic [POS_W-1:0]   fr_pos;
    logic [BYTE_W-1:0]  fr_id;
    logic [BYTE_W-1:0]  fr_len;
    logic [BYTE_W-1:0]  run_sum;
    logic [BYTE_W-1:0]  run_add;
    logic [BYTE_W-1:0]  rcv_sum;
    logic [BYTE_W-1:0]  head_pl [3];
    logic [BYTE_W-1:0]  exp_sync;
    logic [BYTE_W-1:0]  exp_addr;

    int                 n_fail = 0;
    int                 n_results = 0;
    int                 n_bytes_taken = 0;
    int                 quiet_cycles = 0;
    int                 send_gap = 0;
    int                 recv_hold = 0;
    bit                 long_hold_done = 0;
    int                 stall_cycles = 0;
    logic               tail_calm;

    assign tail_calm = (n_bytes_total - n_bytes_taken) < CALM_TAIL;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_rx(input logic [BYTE_W-1:0] b);
        t_feed_beat fb;
        fb.is_cfg  = 1'b0;
        fb.cfg_idx = CFG_SYNC_BYTE;
        fb.data    = b;
        feed_q.push_back(fb);
        n_bytes_total++;
    endtask

    task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        t_feed_beat fb;
        fb.is_cfg  = 1'b1;
        fb.cfg_idx = idx;
        fb.data    = val;
        feed_q.push_back(fb);
        if (idx == CFG_SYNC_BYTE) gen_sync = val;
        else gen_addr = val;
    endtask

    // push a byte and fold it into the frame checks being built
    task automatic push_summed(input logic [BYTE_W-1:0] b);
        push_rx(b);
        gen_sum = gen_sum + b;
        gen_add = gen_add + gen_sum;
    endtask

    task automatic send_header(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len,
                               input bit bcast);
        gen_sum = '0;
        gen_add = '0;
        push_summed(gen_sync);
        push_summed(bcast ? ADDR_BCAST : gen_addr);
        push_summed(id);
        push_summed(len);
    endtask

    // corrupt: 0 good checks, 1 bad sum check, 2 bad add check
    task automatic send_frame(input logic [BYTE_W-1:0] id, input int len, input int corrupt,
                              input bit bcast);
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] a;
        send_header(id, len[BYTE_W-1:0], bcast);
        for (int k = 0; k < len; k++) push_summed(pl_buf[k]);
        s = gen_sum;
        a = gen_add;
        if (corrupt == 1) s = s ^ BYTE_W'($urandom_range(1, 255));
        if (corrupt == 2) a = a ^ BYTE_W'($urandom_range(1, 255));
        push_rx(s);
        push_rx(a);
    endtask

    // how: 0 bad address, 1 length over the limit, 2 frame cut short
    task automatic send_broken(input int how);
        logic [BYTE_W-1:0] bad;
        int len;
        case (how)
            0: begin
                do bad = BYTE_W'($urandom); while (bad == gen_addr || bad == ADDR_BCAST);
                push_rx(gen_sync);
                push_rx(bad);
            end
            1: send_header(BYTE_W'($urandom), BYTE_W'($urandom_range(MAX_PAYLOAD_DEF + 1, 255)),
                           $urandom_range(0, 1));
            default: begin
                len = $urandom_range(3, 8);
                send_header(BYTE_W'($urandom), BYTE_W'(len), 1'b0);
                repeat ($urandom_range(0, len - 1)) push_rx(BYTE_W'($urandom));
            end
        endcase
    endtask

    task automatic send_random_frame();
        int len;
        int r;
        logic [BYTE_W-1:0] id;
        r = $urandom_range(0, 99);
        len = (r < 88) ? $urandom_range(0, 8) :
              (r < 98) ? $urandom_range(9, 40) : $urandom_range(100, MAX_PAYLOAD_DEF);
        for (int k = 0; k < 256; k++) pl_buf[k] = BYTE_W'($urandom);
        case ($urandom_range(0, 3))
            0: begin
                id = ID_CAL;
                if ($urandom_range(0, 9) != 0) pl_buf[0] = CAL_GROUP;
                pl_buf[2] = CAL_CODES[$urandom_range(0, 4)];
            end
            1, 2: begin
                id = ($urandom_range(0, 1) == 0) ? ID_READ : ID_WRITE;
                pl_buf[0] = BYTE_W'($urandom_range(0, 40));
                if ($urandom_range(0, 4) != 0) pl_buf[1] = '0;
            end
            default: id = BYTE_W'($urandom);
        endcase
        r = $urandom_range(0, 19);
        send_frame(id, len, (r == 0) ? 1 : (r == 1) ? 2 : 0, $urandom_range(0, 3) == 0);
    endtask

    task automatic cal_frame(input logic [BYTE_W-1:0] grp, input logic [BYTE_W-1:0] code,
                             input int corrupt);
        pl_buf[0] = grp;
        pl_buf[1] = BYTE_W'($urandom);
        pl_buf[2] = code;
        send_frame(ID_CAL, 3, corrupt, 1'b0);
    endtask

    task automatic param_frame(input logic [BYTE_W-1:0] id, input logic [PID_W-1:0] pid,
                               input int len, input int corrupt);
        pl_buf[0] = pid[7:0];
        pl_buf[1] = pid[15:8];
        pl_buf[2] = BYTE_W'($urandom);
        pl_buf[3] = BYTE_W'($urandom);
        send_frame(id, len, corrupt, 1'b0);
    endtask

    task automatic build_stimulus();
        logic [BYTE_W-1:0] ph_sync [PHASES];
        logic [BYTE_W-1:0] ph_addr [PHASES];
        int phase_end;
        int r;
        ph_sync = '{8'h00, 8'hFF, 8'h5A, BYTE_W'($urandom), 8'hE0, SYNC_RST};
        ph_addr = '{8'h00, 8'hFF, 8'h80, BYTE_W'($urandom), 8'h01, ADDR_RST};

        // directed frames at reset settings
        push_rx(8'h00);
        push_rx(8'h55);
        push_rx(8'hFF);
        send_frame(8'h00, 0, 0, 1'b0);                 // empty payload
        push_rx(gen_sync);                             // address equal to sync:
        push_rx(gen_sync);                             // dropped, not a new frame
        cal_frame(CAL_GROUP, CAL_GYRO, 0);
        send_header(ID_CAL, 8'd129, 1'b0);             // just over the length limit
        send_header(ID_CAL, 8'd255, 1'b1);
        foreach (CAL_CODES[i]) cal_frame(CAL_GROUP, CAL_CODES[i], 0);
        cal_frame(CAL_GYRO, CAL_GYRO, 0);              // wrong calibration group
        send_frame(ID_CAL, 0, 0, 1'b1);                // short payload reads as zero
        param_frame(ID_READ, 16'd31, 2, 0);
        param_frame(ID_READ, 16'd32, 2, 0);
        param_frame(ID_READ, 16'h0100, 2, 0);
        param_frame(ID_READ, 16'hFF05, 1, 0);          // only the low byte received
        param_frame(ID_WRITE, 16'd0, 2, 0);
        param_frame(ID_WRITE, 16'hFFFF, 4, 0);
        cal_frame(CAL_GROUP, CAL_MAG, 1);              // bad sum check
        param_frame(ID_WRITE, 16'd3, 2, 2);            // bad add check
        for (int k = 0; k < MAX_PAYLOAD_DEF; k++) pl_buf[k] = BYTE_W'($urandom);
        send_frame(BYTE_W'($urandom), MAX_PAYLOAD_DEF, 0, 1'b1);
        send_broken(2);

        // random phases, each under its own settings
        for (int ph = 0; ph < PHASES; ph++) begin
            push_cfg(CFG_SYNC_BYTE, ph_sync[ph]);
            push_cfg(CFG_DEV_ADDR, ph_addr[ph]);
            phase_end = ITEMS * (ph + 1) / PHASES;
            while (n_bytes_total < phase_end) begin
                r = $urandom_range(0, 99);
                if (r < 75) send_random_frame();
                else if (r < 88) send_broken($urandom_range(0, 2));
                else repeat ($urandom_range(1, 8))
                    push_rx(($urandom_range(0, 5) == 0) ? gen_sync : BYTE_W'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Predictor of the deframer
    // ------------------------------------------------------------------
    task automatic fold_in(input logic [BYTE_W-1:0] b);
        run_sum = run_sum + b;
        run_add = run_add + run_sum;
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        t_result r;
        int p;
        int ln;
        int k;
        logic ok;
        logic [PID_W-1:0] pid;
        p  = fr_pos;
        ln = fr_len;
        r  = '0;
        if (fr_pos == POS_HUNT) begin
            if (b == exp_sync) begin
                head_pl = '{default: '0};
                run_sum = '0;
                run_add = '0;
                fold_in(b);
                fr_pos = POS_ADDR;
            end
        end else if (fr_pos == POS_ADDR) begin
            if (b == exp_addr || b == ADDR_BCAST) begin
                fold_in(b);
                fr_pos = POS_ID;
            end else begin
                fr_pos = POS_HUNT;
            end
        end else if (fr_pos == POS_ID) begin
            fr_id = b;
            fold_in(b);
            fr_pos = POS_LEN;
        end else if (fr_pos == POS_LEN) begin
            if (int'(b) > MAX_PAYLOAD_DEF) begin
                fr_pos = POS_HUNT;
            end else begin
                fr_len = b;
                fold_in(b);
                fr_pos = POS_PAY;
            end
        end else if (p < int'(POS_PAY) + ln) begin
            // tentative payload beat
            k = p - int'(POS_PAY);
            if (k < 3) head_pl[k] = b;
            fold_in(b);
            fr_pos = fr_pos + 1'b1;
            r.kind         = KIND_PAYLOAD;
            r.byte_index   = BYTE_W'(k);
            r.payload_byte = b;
            r.frame_id     = fr_id;
            r.frame_len    = fr_len;
            expected_results.push_back(r);
        end else if (p == int'(POS_PAY) + ln) begin
            rcv_sum = b;
            fr_pos = fr_pos + 1'b1;
        end else if (p == int'(POS_PAY) + ln + 1) begin
            // frame end: verdict and dispatch
            ok  = (rcv_sum == run_sum) && (b == run_add);
            pid = {head_pl[1], head_pl[0]};
            r.kind      = KIND_END;
            r.frame_id  = fr_id;
            r.frame_len = fr_len;
            r.check_ok  = ok;
            r.sum_value = run_sum;
            r.add_value = run_add;
            r.param_id  = pid;
            r.action    = ACT_NONE;
            if (ok && fr_id == ID_CAL) begin
                r.reply_needed = 1'b1;
                if (head_pl[0] == CAL_GROUP) begin
                    case (head_pl[2])
                        CAL_GYRO:       r.action = ACT_GYRO_CAL;
                        CAL_MAG:        r.action = ACT_MAG_CAL;
                        CAL_ACC:        r.action = ACT_ACC_CAL;
                        CAL_CANCEL_MAG: r.action = ACT_CANCEL_MAG;
                        default:        r.action = ACT_NONE;
                    endcase
                end
            end else if (ok && fr_id == ID_READ) begin
                if (int'(pid) < CMD_SLOTS_DEF) r.action = ACT_PARAM_RD;
            end else if (ok && fr_id == ID_WRITE) begin
                r.reply_needed = 1'b1;
                if (int'(pid) < CMD_SLOTS_DEF) r.action = ACT_PARAM_WR;
            end
            fr_pos = POS_HUNT;
            expected_results.push_back(r);
        end else begin
            fr_pos = POS_HUNT;
        end
    endtask

    // ------------------------------------------------------------------
    // Result comparison
    // ------------------------------------------------------------------
    task automatic cmp_field(input string nm, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            n_fail++;
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, nm, want, got);
        end
    endtask

    task automatic check_result(input t_result want, input t_result got);
        cmp_field("kind", 16'(want.kind), 16'(got.kind));
        cmp_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
        cmp_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        cmp_field("frame_id", 16'(want.frame_id), 16'(got.frame_id));
        cmp_field("frame_len", 16'(want.frame_len), 16'(got.frame_len));
        cmp_field("check_ok", 16'(want.check_ok), 16'(got.check_ok));
        cmp_field("sum_value", 16'(want.sum_value), 16'(got.sum_value));
        cmp_field("add_value", 16'(want.add_value), 16'(got.add_value));
        cmp_field("action", 16'(want.action), 16'(got.action));
        cmp_field("reply_needed", 16'(want.reply_needed), 16'(got.reply_needed));
        cmp_field("param_id", want.param_id, got.param_id);
    endtask

    // ------------------------------------------------------------------
    // Driver: byte and register beats from the feed queue
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
            send_gap = 0;
        end else if ((i_in_valid && !o_in_ready) || (i_cfg_valid && !o_cfg_ready)) begin
            // beat still offered: hold valid and payload
        end else if (send_gap != 0) begin
            send_gap--;
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if (feed_q.size() == 0) begin
            i_in_valid  <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else if (feed_q[0].is_cfg) begin
            // register writes only once the block has drained
            i_in_valid <= 1'b0;
            if (quiet_cycles >= CFG_DRAIN) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= feed_q[0].cfg_idx;
                i_cfg_data  <= feed_q[0].data;
                void'(feed_q.pop_front());
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end else begin
            i_cfg_valid <= 1'b0;
            i_in_valid  <= 1'b1;
            i_rx_byte   <= feed_q[0].data;
            void'(feed_q.pop_front());
            if (!tail_calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 16);
        end
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_hold = 0;
            long_hold_done = 0;
        end else if (recv_hold != 0) begin
            recv_hold--;
            i_out_ready <= 1'b0;
        end else if (!long_hold_done && n_results >= 80) begin
            long_hold_done = 1;
            recv_hold = LONG_HOLD;
            i_out_ready <= 1'b0;
        end else if (!tail_calm && $urandom_range(0, 7) == 0) begin
            recv_hold = $urandom_range(0, 15);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track accepted beats, predict and check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            fr_pos   = POS_HUNT;
            fr_id    = '0;
            fr_len   = '0;
            run_sum  = '0;
            run_add  = '0;
            rcv_sum  = '0;
            head_pl  = '{default: '0};
            exp_sync = SYNC_RST;
            exp_addr = ADDR_RST;
            expected_results.delete();
            quiet_cycles <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got.kind         = o_kind;
                got.byte_index   = o_byte_index;
                got.payload_byte = o_payload_byte;
                got.frame_id     = o_frame_id;
                got.frame_len    = o_frame_len;
                got.check_ok     = o_check_ok;
                got.sum_value    = o_sum_value;
                got.add_value    = o_add_value;
                got.action       = o_action;
                got.reply_needed = o_reply_needed;
                got.param_id     = o_param_id;
                if (expected_results.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result: expected none actual kind %0d id %0h",
                             $time, got.kind, got.frame_id);
                end else begin
                    check_result(expected_results.pop_front(), got);
                end
                n_results <= n_results + 1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_SYNC_BYTE) exp_sync = i_cfg_data;
                else if (i_cfg_index == CFG_DEV_ADDR) exp_addr = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                deframe_byte(i_rx_byte);
                n_bytes_taken <= n_bytes_taken + 1;
            end
            quiet_cycles <= (expected_results.size() == 0 && !i_in_valid && !o_out_valid) ?
                            quiet_cycles + 1 : 0;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no beat on any channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (i_cfg_valid && o_cfg_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no beat for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: build stimulus, reset, wait for drain, verdict
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (feed_q.size() != 0 || i_in_valid || i_cfg_valid || expected_results.size() != 0);
        repeat (8) @(negedge i_clk);
        if (n_fail == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
